// File: rtl/base64_encoder_assert.svh
// assertion macros used by the base64 encoder checker
`ifndef BASE64_ENCODER_ASSERT_SVH
`define BASE64_ENCODER_ASSERT_SVH

// concurrent assertion on an explicit clock and active-low reset
`define B64E_ASSERT_AT(label, clock, rst_n, prop, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) prop) \
		else $error(msg);

// concurrent assertion on the usual clk and arst_n
`define B64E_ASSERT(label, prop, msg) `B64E_ASSERT_AT(label, clk, arst_n, prop, msg)

`endif

// File: rtl/b64e_pkg.sv
// shared types, constants and the character table of the base64 encoder
package b64e_pkg;

	// one complete or padded 24-bit group handed from front to back
	typedef struct packed {
		logic [23:0] group;
		logic [1:0]  n_pad;
		logic        last;
	} b64e_group_t;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] PAD_CHAR   = 8'h3D;
	localparam logic [7:0] CHAR_UPPER = 8'h41;
	localparam logic [7:0] CHAR_LOWER = 8'h61;
	localparam logic [7:0] CHAR_DIGIT = 8'h30;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;

	// 6-bit value to its base64 alphabet character
	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] r;
		case (v) inside
			[6'd0:6'd25]:  r = CHAR_UPPER + {2'b00, v};
			[6'd26:6'd51]: r = CHAR_LOWER + {2'b00, v} - 8'd26;
			[6'd52:6'd61]: r = CHAR_DIGIT + {2'b00, v} - 8'd52;
			6'd62:         r = CHAR_PLUS;
			default:       r = CHAR_SLASH;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/base64_encoder.sv
// base64 encoder: bytes in, standard alphabet characters with padding out
// groups pass the group queue and the current group register before the output register
// throughput: one byte accepted per cycle while the group queue has room
// the output side drives one character per cycle while out_ready allows, four for every 3 bytes
// reset: arst_n clears pending bytes, position, queue and output valid at once
module base64_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       end_of_message,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       last_char
);

	b64e_pkg::b64e_group_t push_group;
	b64e_pkg::b64e_group_t pop_group;
	logic                  push;
	logic                  pop;
	logic                  queue_full;
	logic                  queue_empty;

	// byte gathering
	b64e_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.queue_full     (queue_full),
		.push           (push),
		.push_group     (push_group)
	);

	// group queue
	b64e_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_group (push_group),
		.pop        (pop),
		.pop_group  (pop_group),
		.full       (queue_full),
		.empty      (queue_empty)
	);

	// character output
	b64e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (queue_empty),
		.pop_group (pop_group),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.last_char (last_char)
	);

endmodule

// File: rtl/b64e_front.sv
// input side: gathers bytes into groups and pushes finished groups to the queue
module b64e_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             data_byte,
	input  logic                   end_of_message,
	input  logic                   queue_full,
	output logic                   push,
	output b64e_pkg::b64e_group_t  push_group
);

	logic [15:0] pending_q;
	logic [1:0]  pos_q;
	logic        accept;
	logic        complete;

	// handshake and group completion
	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign complete = (pos_q == 2'd2) || end_of_message;
	assign push     = accept && complete;

	// build the padded group from pending bytes and the new byte
	always_comb begin
		push_group.last = end_of_message;
		case (pos_q)
			2'd2: begin
				push_group.group = {pending_q, data_byte};
				push_group.n_pad = 2'd0;
			end
			2'd1: begin
				push_group.group = {pending_q[7:0], data_byte, 8'h00};
				push_group.n_pad = 2'd1;
			end
			default: begin
				push_group.group = {data_byte, 16'h0000};
				push_group.n_pad = 2'd2;
			end
		endcase
	end

	// pending bytes and position count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			pos_q     <= '0;
		end else if (accept) begin
			if (complete) begin
				pending_q <= '0;
				pos_q     <= '0;
			end else begin
				pending_q <= {pending_q[7:0], data_byte};
				pos_q     <= pos_q + 2'd1;
			end
		end
	end

endmodule

// File: rtl/b64e_queue.sv
// short register queue of groups between front and back
module b64e_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  b64e_pkg::b64e_group_t  push_group,
	input  logic                   pop,
	output b64e_pkg::b64e_group_t  pop_group,
	output logic                   full,
	output logic                   empty
);

	b64e_pkg::b64e_group_t              mem_q [b64e_pkg::QUEUE_DEPTH];
	logic [b64e_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [b64e_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [b64e_pkg::QCNT_W-1:0]        cnt_q;
	logic                               do_push;
	logic                               do_pop;

	// status
	assign full      = (cnt_q == b64e_pkg::QCNT_W'(b64e_pkg::QUEUE_DEPTH));
	assign empty     = (cnt_q == '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && !empty;
	assign pop_group = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_group;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				if (wr_ptr_q == b64e_pkg::QPTR_W'(b64e_pkg::QUEUE_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (do_pop) begin
				if (rd_ptr_q == b64e_pkg::QPTR_W'(b64e_pkg::QUEUE_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/b64e_back.sv
// output side: turns one queued group into four characters, one per cycle while out_ready allows
module b64e_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   empty,
	input  b64e_pkg::b64e_group_t  pop_group,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             out_char,
	output logic                   last_char
);

	b64e_pkg::b64e_group_t cur_q;
	logic                  cur_v_q;
	logic [1:0]            idx_q;
	logic [7:0]            out_char_q;
	logic                  last_q;
	logic                  out_valid_q;
	logic                  advance;
	logic                  finish;
	logic [5:0]            sextet;
	logic                  is_data;
	logic [7:0]            next_char;

	// move a character into the output register when it is free or drains
	assign advance = cur_v_q && (!out_valid_q || out_ready);
	assign finish  = advance && (idx_q == 2'd3);
	assign pop     = !empty && (!cur_v_q || finish);

	// select the sextet, most significant first, then map or pad
	always_comb begin
		case (idx_q)
			2'd0:    sextet = cur_q.group[23:18];
			2'd1:    sextet = cur_q.group[17:12];
			2'd2:    sextet = cur_q.group[11:6];
			default: sextet = cur_q.group[5:0];
		endcase
		is_data   = ({1'b0, idx_q} < (3'd4 - {1'b0, cur_q.n_pad}));
		next_char = is_data ? b64e_pkg::b64_char(sextet) : b64e_pkg::PAD_CHAR;
	end

	// current group
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_group;
		end
	end

	// character payload
	always_ff @(posedge clk) begin
		if (advance) begin
			out_char_q <= next_char;
			last_q     <= cur_q.last && (idx_q == 2'd3);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q     <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_v_q <= 1'b1;
			end else if (finish) begin
				cur_v_q <= 1'b0;
			end
			if (advance) begin
				idx_q <= idx_q + 2'd1;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last_char = last_q;

endmodule

// File: rtl/b64e_checker.sv
// port-level checker for the base64 encoder and its bind
`include "base64_encoder_assert.svh"

module b64e_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] data_byte,
	input logic       end_of_message,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       last_char
);

	logic [1:0] pos_q;
	logic       pad_q;
	logic       out_xfer;
	logic       in_stall;

	assign out_xfer = out_valid && out_ready;
	assign in_stall = in_valid && !in_ready;

	// track the character position within each group of four
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			pad_q <= 1'b0;
		end else if (out_xfer) begin
			pos_q <= pos_q + 2'd1;
			if (pos_q == 2'd3) begin
				pad_q <= 1'b0;
			end else if (out_char == b64e_pkg::PAD_CHAR) begin
				pad_q <= 1'b1;
			end
		end
	end

	// a stalled input transaction holds its payload
	`B64E_ASSERT(a_in_hold, in_stall |=> in_valid && $stable(data_byte) && $stable(end_of_message), "input changed while stalled")

	// a stalled output transaction holds its payload
	`B64E_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last_char), "output changed while stalled")

	// the message end falls only on the fourth character of a group
	`B64E_ASSERT(a_last_pos, out_xfer && last_char |-> pos_q == 2'd3, "last_char off a group boundary")

	// padding only in the third or fourth place
	`B64E_ASSERT(a_pad_pos, out_xfer && out_char == b64e_pkg::PAD_CHAR |-> pos_q == 2'd2 || pos_q == 2'd3, "padding too early in group")

	// once padding starts the group ends padded and marked last
	`B64E_ASSERT(a_pad_tail, out_xfer && pos_q == 2'd3 && pad_q |-> out_char == b64e_pkg::PAD_CHAR && last_char, "padded group ends badly")

endmodule

bind base64_encoder b64e_checker u_b64e_checker (.*);

// File: verif/base64_encoder_tb.sv
// self-checking testbench for the base64 encoder: directed and random byte streams
module base64_encoder_tb;

	localparam logic [511:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int RANDOM_BYTES = 320;

	// encodes accepted bytes into expected characters and matches them against the output
	class char_scoreboard;
		logic [15:0] held_bytes;
		logic [1:0]  held_count;
		logic [8:0]  expected_chars[$];
		int unsigned errors;

		function new();
			held_bytes = 16'h0000;
			held_count = 2'd0;
			errors = 0;
		endfunction

		function void note_byte(input logic [7:0] b, input logic eom);
			logic [23:0] grp;
			logic [5:0]  sextet;
			logic [7:0]  ch;
			int          nreal;
			// third byte of a group always flushes, end of message flushes a short group
			if (held_count == 2'd2) begin
				grp = {held_bytes, b};
				nreal = 4;
			end else if (!eom) begin
				held_bytes = {held_bytes[7:0], b};
				held_count = held_count + 2'd1;
				return;
			end else if (held_count == 2'd1) begin
				grp = {held_bytes[7:0], b, 8'h00};
				nreal = 3;
			end else begin
				grp = {b, 16'h0000};
				nreal = 2;
			end
			held_bytes = 16'h0000;
			held_count = 2'd0;
			// four characters, most significant sextet first, padding at the tail
			for (int k = 0; k < 4; k++) begin
				sextet = grp[23 - 6 * k -: 6];
				ch = (k < nreal) ? ALPHABET[511 - 8 * sextet -: 8] : b64e_pkg::PAD_CHAR;
				expected_chars.push_back({eom && (k == 3), ch});
			end
		endfunction

		function void check_char(input logic [7:0] c, input logic lst);
			logic [8:0] exp_entry;
			if (expected_chars.size() == 0) begin
				$error("out_char: no transaction expected, got %h (last_char %b)", c, lst);
				errors++;
				return;
			end
			exp_entry = expected_chars.pop_front();
			if (c !== exp_entry[7:0]) begin
				$error("out_char: expected %h, got %h", exp_entry[7:0], c);
				errors++;
			end
			if (lst !== exp_entry[8]) begin
				$error("last_char: expected %b, got %b", exp_entry[8], lst);
				errors++;
			end
		endfunction

		function int outstanding();
			return expected_chars.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] data_byte;
	logic       end_of_message;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_char;
	logic       last_char;

	char_scoreboard sb;
	int unsigned    send_idle_pct;
	int unsigned    recv_stall_pct;
	int unsigned    cycle_count;

	base64_encoder DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_char       (out_char),
		.last_char      (last_char)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_char(out_char, last_char);
	end

	// drive one byte, with random idle cycles ahead of it, and wait for acceptance
	task automatic send_byte(input logic [7:0] b, input logic eom);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_message <= eom;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_byte(b, eom);
	endtask

	// random byte, biased toward the extremes now and then
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// mostly well-formed messages, some bursts with random end flags
	task automatic random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
			input int nbytes);
		int sent;
		int len;
		sent = 0;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		while (sent < nbytes) begin
			len = $urandom_range(10, 1);
			if ($urandom_range(9) < 8) begin
				for (int i = 0; i < len; i++)
					send_byte(pick_byte(), i == len - 1);
			end else begin
				for (int i = 0; i < len; i++)
					send_byte(pick_byte(), 1'($urandom_range(1)));
			end
			sent += len;
		end
	endtask

	// reset, stimulus and end of run
	initial begin
		sb = new();
		cycle_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		end_of_message = 1'b0;
		out_ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// one byte messages, two padding characters
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		// two byte message, one padding character
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		// full group on the last byte, top of the alphabet
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFB, 1'b0);
		send_byte(8'hEF, 1'b0);
		send_byte(8'hBE, 1'b1);
		// full group without end of message, then a padded tail
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h80, 1'b1);
		send_byte(8'h01, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'h03, 1'b0);
		send_byte(8'hFE, 1'b0);
		send_byte(8'hFD, 1'b1);

		random_phase(0, 0, RANDOM_BYTES / 4);
		random_phase(63, 0, RANDOM_BYTES / 4);
		random_phase(0, 63, RANDOM_BYTES / 4);
		random_phase(30, 30, RANDOM_BYTES / 4);
		in_valid <= 1'b0;

		// drain, then give stray characters a chance to show up
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
